/* sv/itca_pkg.sv */
// ----------------------------------------------------------------------------
// itca_pkg
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none
package itca_pkg;
   localparam int MISS_SLOTS = 16;
   localparam int ADDR_BITS  = 48;
   localparam int TIME_BITS  = 48;

   localparam logic [3:0] ACT_MISS    = 4'd0;
   localparam logic [3:0] ACT_SQUASH  = 4'd1;
   localparam logic [3:0] ACT_RESOLVE = 4'd2;
   localparam logic [3:0] ACT_MARK    = 4'd3;
   localparam logic [3:0] ACT_STALL   = 4'd4;
   localparam logic [3:0] ACT_RESUME  = 4'd5;
   localparam logic [3:0] ACT_HEAD    = 4'd6;
   localparam logic [3:0] ACT_CLEAR   = 4'd7;
   localparam logic [3:0] ACT_EMPTY   = 4'd8;
   localparam logic [3:0] ACT_NONEMP  = 4'd9;
   localparam logic [3:0] ACT_SAMPLE  = 4'd10;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   localparam logic CSR_STALL_SRC = 1'b0;
   localparam logic CSR_ITIP      = 1'b1;

   typedef struct packed {
      logic load;    // capture request beat
      logic update;  // table update + signal compute
      logic evaluate; // gate and timer update
      logic sample;  // sample totals
      logic present; // load result register
   } itca_cmd_type;

   typedef struct packed {
      logic [3:0] action;
      logic       stall_match;
   } itca_stat_type;
endpackage
`default_nettype wire

/* sv/intertask_conflict_cycle_accounting.sv */
// ----------------------------------------------------------------------------
// intertask_conflict_cycle_accounting
// Intertask-conflict-aware cycle accounting with data and instruction
// pending-miss tables.
//
//   channel | direction | handshake
//   req_    | in        | req_valid / req_stall
//   rsp_    | out       | rsp_valid / rsp_stall
//   csr_    | in        | csr_write, no wait
//
// An event steps through capture, table update, gate evaluation and result
// load, set by the sequencer; squash, sample, no-op codes and ignored stalls
// skip the gate evaluation. The result beat is valid from the cycle after the load.
// Reset is synchronous; no clearing pass is needed.
// A stalled result holds in its register; the next beat is still taken and
// waits in the load step until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module intertask_conflict_cycle_accounting import itca_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [3:0]           req_action,
   input  wire logic                 req_table_select,
   input  wire logic [ADDR_BITS-1:0] req_line_addr,
   input  wire logic [ADDR_BITS-1:0] req_cpu_addr,
   input  wire logic [1:0]           req_stall_kind,
   input  wire logic [TIME_BITS-1:0] req_now,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_accounting_now,
   output logic [TIME_BITS-1:0]      rsp_accounted_cycles,
   output logic [TIME_BITS-1:0]      rsp_stall_cycles,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic [1:0]           csr_data
);
   itca_cmd_type  cmd;
   itca_stat_type stat;

   itca_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .stat, .cmd
   );

   itca_dp u_dp (
      .clock, .reset, .cmd, .stat, .csr_write, .csr_index, .csr_data,
      .req_action, .req_table_select, .req_line_addr, .req_cpu_addr,
      .req_stall_kind, .req_now, .rsp_status, .rsp_accounting_now,
      .rsp_accounted_cycles, .rsp_stall_cycles
   );
endmodule
`default_nettype wire

/* sv/itca_ctrl.sv */
// ----------------------------------------------------------------------------
// itca_ctrl
// Event sequencer: accept, update tables, evaluate gate, present result.
// ----------------------------------------------------------------------------
`default_nettype none
module itca_ctrl import itca_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   input  wire itca_stat_type stat,
   output itca_cmd_type      cmd
);
   typedef enum logic [1:0] {S_IDLE, S_UPD, S_EVAL, S_OUT} state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      do_eval;

   assign do_eval = !(stat.action == ACT_SQUASH || stat.action == ACT_SAMPLE
                      || stat.action > ACT_SAMPLE ||
                      ((stat.action == ACT_STALL || stat.action == ACT_RESUME)
                       && !stat.stall_match));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_stall    = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            cmd.load = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            cmd.sample = (stat.action == ACT_SAMPLE);
            state_in   = do_eval ? S_EVAL : S_OUT;
         end
         S_EVAL: begin
            cmd.evaluate = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: if (!(rsp_valid_ff && rsp_stall)) begin
            cmd.present  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_UPD) else $error("load not followed by update");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.update, cmd.evaluate, cmd.present}))
      else $error("command overlap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
endmodule
`default_nettype wire

/* sv/itca_dp.sv */
// ----------------------------------------------------------------------------
// itca_dp
// Miss tables, signal bits, accounting timers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module itca_dp import itca_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire itca_cmd_type         cmd,
   output itca_stat_type             stat,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic [1:0]           csr_data,
   input  wire logic [3:0]           req_action,
   input  wire logic                 req_table_select,
   input  wire logic [ADDR_BITS-1:0] req_line_addr,
   input  wire logic [ADDR_BITS-1:0] req_cpu_addr,
   input  wire logic [1:0]           req_stall_kind,
   input  wire logic [TIME_BITS-1:0] req_now,
   output logic [1:0]                rsp_status,
   output logic                      rsp_accounting_now,
   output logic [TIME_BITS-1:0]      rsp_accounted_cycles,
   output logic [TIME_BITS-1:0]      rsp_stall_cycles
);
   logic [3:0]           act_ff;
   logic                 sel_ff;
   logic [ADDR_BITS-1:0] la_ff, ca_ff;
   logic [1:0]           kind_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [1:0]           src_ff;
   logic                 pol_ff;

   logic [ADDR_BITS-1:0] daddr_ff [MISS_SLOTS];
   logic [ADDR_BITS-1:0] dcpu_ff  [MISS_SLOTS];
   logic [ADDR_BITS-1:0] iaddr_ff [MISS_SLOTS];
   logic [MISS_SLOTS-1:0] dval_ff, dint_ff, ival_ff, iint_ff;
   logic robe_ff, stallsig_ff;
   logic [ADDR_BITS-1:0] head_ff;
   logic acc_on_ff, stall_on_ff;
   logic [TIME_BITS-1:0] acc_at_ff, acc_cnt_ff, unacc_cnt_ff;
   logic [TIME_BITS-1:0] st_at_ff, st_cnt_ff, nst_cnt_ff;
   logic [1:0] status_ff;
   logic [TIME_BITS-1:0] smp_acc_ff, smp_st_ff;
   logic [1:0]           out_status_ff;
   logic                 out_acct_ff;
   logic [TIME_BITS-1:0] out_acc_ff, out_st_ff;

   // match and free vectors for the captured event
   logic [MISS_SLOTS-1:0] dmatch, imatch, dfree, ifree, dlow, ilow, dfl, ifl;
   always_comb begin
      for (int i = 0; i < MISS_SLOTS; i++) begin
         dmatch[i] = dval_ff[i] && daddr_ff[i] == la_ff;
         imatch[i] = ival_ff[i] && iaddr_ff[i] == la_ff;
      end
      dfree = ~dval_ff;
      ifree = ~ival_ff;
      dlow  = dmatch & (~dmatch + 1'b1);
      ilow  = imatch & (~imatch + 1'b1);
      dfl   = dfree & (~dfree + 1'b1);
      ifl   = ifree & (~ifree + 1'b1);
   end

   // signals computed from table state after update (registered in update step)
   logic [MISS_SLOTS-1:0] dval_n, dint_n, ival_n, iint_n;
   logic [ADDR_BITS-1:0]  head_n;
   logic [1:0]            st_n;
   logic                  robe_n, stall_n;
   always_comb begin
      dval_n = dval_ff; dint_n = dint_ff; ival_n = ival_ff; iint_n = iint_ff;
      head_n = head_ff; st_n = ST_OK; robe_n = robe_ff; stall_n = stallsig_ff;
      case (act_ff)
         ACT_MISS: if (!sel_ff) begin
            if (dfl == '0) st_n = ST_FULL;
            else begin dval_n = dval_ff | dfl; dint_n = dint_ff & ~dfl; end
         end else begin
            if (ifl == '0) st_n = ST_FULL;
            else begin ival_n = ival_ff | ifl; iint_n = iint_ff & ~ifl; end
         end
         ACT_SQUASH: begin
            dval_n = dval_ff & ~dlow; dint_n = dint_ff & ~dlow;
            ival_n = ival_ff & ~ilow; iint_n = iint_ff & ~ilow;
         end
         ACT_RESOLVE: if (!sel_ff) begin
            if (dlow == '0) st_n = ST_NOTFOUND;
            else begin dval_n = dval_ff & ~dlow; dint_n = dint_ff & ~dlow; end
         end else begin
            if (ilow == '0) st_n = ST_NOTFOUND;
            else begin ival_n = ival_ff & ~ilow; iint_n = iint_ff & ~ilow; end
         end
         ACT_MARK: if (!sel_ff) begin
            if (dlow == '0) st_n = ST_NOTFOUND; else dint_n = dint_ff | dlow;
         end else begin
            if (ilow == '0) st_n = ST_NOTFOUND; else iint_n = iint_ff | ilow;
         end
         ACT_STALL, ACT_RESUME: if (kind_ff == src_ff) stall_n = (act_ff == ACT_STALL);
         ACT_HEAD:   head_n = la_ff;
         ACT_CLEAR:  head_n = '0;
         ACT_EMPTY:  robe_n = 1'b1;
         ACT_NONEMP: robe_n = 1'b0;
         default: ;
      endcase
   end

   // signal evaluation reads registered table state (evaluate step)
   logic top_c, alli_c, iti_c, anyi;
   always_comb begin
      top_c = 1'b0;
      for (int i = 0; i < MISS_SLOTS; i++)
         if (dval_ff[i] && dint_ff[i] && dcpu_ff[i] == head_ff) top_c = 1'b1;
      alli_c = (dval_ff != '0) && ((dval_ff & ~dint_ff) == '0);
      anyi   = (ival_ff & iint_ff) != '0;
      iti_c  = pol_ff ? ((ival_ff & ~iint_ff) == '0) : anyi;
   end

   logic port2, stop;
   logic [TIME_BITS-1:0] alen, slen;
   assign port2 = top_c && stallsig_ff;
   assign stop  = (iti_c && robe_ff) || port2 || alli_c;
   assign alen  = now_ff - acc_at_ff;
   assign slen  = now_ff - st_at_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action; sel_ff <= req_table_select;
         la_ff <= req_line_addr; ca_ff <= req_cpu_addr;
         kind_ff <= req_stall_kind; now_ff <= req_now;
      end
      if (cmd.update) begin
         for (int i = 0; i < MISS_SLOTS; i++) begin
            if (act_ff == ACT_MISS && !sel_ff && dfl[i]) begin
               daddr_ff[i] <= la_ff; dcpu_ff[i] <= '0;
            end
            if (act_ff == ACT_MISS && sel_ff && ifl[i]) iaddr_ff[i] <= la_ff;
            if (act_ff == ACT_MARK && !sel_ff && dlow[i]) dcpu_ff[i] <= ca_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dval_ff <= '0; dint_ff <= '0; ival_ff <= '0; iint_ff <= '0;
         robe_ff <= 1'b0; stallsig_ff <= 1'b0; head_ff <= '0;
         acc_on_ff <= 1'b1; stall_on_ff <= 1'b0;
         acc_at_ff <= '0; acc_cnt_ff <= '0; unacc_cnt_ff <= '0;
         st_at_ff <= '0; st_cnt_ff <= '0; nst_cnt_ff <= '0;
         src_ff <= 2'd1; pol_ff <= 1'b0; status_ff <= ST_OK;
         smp_acc_ff <= '0; smp_st_ff <= '0;
         out_status_ff <= ST_OK; out_acct_ff <= 1'b1;
         out_acc_ff <= '0; out_st_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_STALL_SRC) src_ff <= csr_data;
            else pol_ff <= csr_data[0];
         end
         if (cmd.update) begin
            dval_ff <= dval_n; dint_ff <= dint_n; ival_ff <= ival_n; iint_ff <= iint_n;
            head_ff <= head_n; robe_ff <= robe_n; stallsig_ff <= stall_n;
            status_ff <= st_n;
            smp_acc_ff <= '0; smp_st_ff <= '0;
         end
         if (cmd.sample) begin
            acc_at_ff <= now_ff; st_at_ff <= now_ff;
            smp_acc_ff <= acc_on_ff ? acc_cnt_ff + alen : acc_cnt_ff;
            smp_st_ff  <= stall_on_ff ? st_cnt_ff + slen : st_cnt_ff;
            acc_cnt_ff <= '0; unacc_cnt_ff <= '0; st_cnt_ff <= '0; nst_cnt_ff <= '0;
         end
         if (cmd.evaluate) begin
            if (acc_on_ff && stop) begin
               acc_on_ff <= 1'b0; acc_cnt_ff <= acc_cnt_ff + alen; acc_at_ff <= now_ff;
            end else if (!acc_on_ff && !stop) begin
               acc_on_ff <= 1'b1; unacc_cnt_ff <= unacc_cnt_ff + alen; acc_at_ff <= now_ff;
            end
            if (stall_on_ff && stop) begin
               stall_on_ff <= 1'b0; st_cnt_ff <= st_cnt_ff + slen; st_at_ff <= now_ff;
            end else if (!stall_on_ff && !stop && port2) begin
               stall_on_ff <= 1'b1; nst_cnt_ff <= nst_cnt_ff + slen; st_at_ff <= now_ff;
            end
         end
         if (cmd.present) begin
            out_status_ff <= status_ff; out_acct_ff <= acc_on_ff;
            out_acc_ff <= smp_acc_ff; out_st_ff <= smp_st_ff;
         end
      end
   end

   assign rsp_status           = out_status_ff;
   assign rsp_accounting_now   = out_acct_ff;
   assign rsp_accounted_cycles = out_acc_ff;
   assign rsp_stall_cycles     = out_st_ff;
   assign stat.action          = act_ff;
   assign stat.stall_match     = (kind_ff == src_ff);

   a_stall_needs_acc: assert property (@(posedge clock) disable iff (reset)
      stall_on_ff |-> acc_on_ff) else $error("stall timed while not accounting");
   a_int_valid: assert property (@(posedge clock) disable iff (reset)
      ((dint_ff & ~dval_ff) == '0) && ((iint_ff & ~ival_ff) == '0))
      else $error("intertask flag on invalid slot");
   a_sq_status: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.update) && act_ff == ACT_SQUASH |-> status_ff == ST_OK)
      else $error("squash raised status");
endmodule
`default_nettype wire

/* tb/sv/intertask_conflict_cycle_accounting_tb.sv */
// ----------------------------------------------------------------------------
// intertask_conflict_cycle_accounting_tb
// Self-checking testbench. A scoreboard class predicts every response beat
// from the accepted request beats: miss tables, gate signals and cycle
// counters. Directed events come first, then random event streams over a
// small address pool, under several CSR settings, with random idle bursts
// on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module intertask_conflict_cycle_accounting_tb import itca_pkg::*;;

   localparam logic [3:0] ACT_NOP = 4'd11;
   localparam int LIMIT = 600000;
   localparam logic [4:0] S_ITI = 5'h01, S_ROBE = 5'h02, S_TOP = 5'h04,
                          S_STALL = 5'h08, S_ALLI = 5'h10;

   typedef struct packed {
      logic [1:0]           status;
      logic                 acct;
      logic [TIME_BITS-1:0] acc;
      logic [TIME_BITS-1:0] stl;
   } rsp_beat_type;

   class itca_scoreboard;
      bit [ADDR_BITS-1:0] d_addr[MISS_SLOTS], d_cpu[MISS_SLOTS], i_addr[MISS_SLOTS];
      bit [1:0]           d_flag[MISS_SLOTS], i_flag[MISS_SLOTS];
      bit [4:0]           sig;
      bit [ADDR_BITS-1:0] head;
      bit                 acct_on, stl_on;
      bit [TIME_BITS-1:0] acct_at, acct_cnt, unacct_cnt, stl_at, stl_cnt, nstl_cnt;
      bit [1:0]           stall_src;
      bit                 policy;
      rsp_beat_type       pending[$];
      int                 errors, checked, fulls, misses_nf, samples;

      function new();
         foreach (d_flag[i]) begin
            d_flag[i] = 0;
            i_flag[i] = 0;
         end
         sig = 0; head = 0; acct_on = 1; stl_on = 0;
         acct_at = 0; acct_cnt = 0; unacct_cnt = 0;
         stl_at = 0; stl_cnt = 0; nstl_cnt = 0;
         stall_src = 1; policy = 0;
      endfunction

      function void set_csr(bit idx, bit [1:0] val);
         if (idx == CSR_STALL_SRC) stall_src = val;
         else policy = val[0];
      endfunction

      function int find_slot(bit instr, bit [ADDR_BITS-1:0] a);
         for (int i = 0; i < MISS_SLOTS; i++) begin
            if (instr ? (i_flag[i][0] && i_addr[i] == a)
                      : (d_flag[i][0] && d_addr[i] == a)) return i;
         end
         return -1;
      endfunction

      function void regate(bit [TIME_BITS-1:0] now);
         bit top, alli, anyd, iti, p1, p2, stop;
         int ic, it;
         top = 0; alli = 1; anyd = 0; ic = 0; it = 0;
         for (int i = 0; i < MISS_SLOTS; i++) begin
            if (d_flag[i][0]) begin
               anyd = 1;
               if (d_flag[i][1]) begin
                  if (d_cpu[i] == head) top = 1;
               end else alli = 0;
            end
            if (i_flag[i][0]) begin
               it++;
               if (i_flag[i][1]) ic++;
            end
         end
         iti = policy ? (ic == it) : (ic >= 1);
         sig = top ? (sig | S_TOP) : (sig & ~S_TOP);
         sig = (anyd && alli) ? (sig | S_ALLI) : (sig & ~S_ALLI);
         sig = iti ? (sig | S_ITI) : (sig & ~S_ITI);
         p1 = (sig & S_ITI) != 0 && (sig & S_ROBE) != 0;
         p2 = (sig & S_TOP) != 0 && (sig & S_STALL) != 0;
         stop = p1 || p2 || (sig & S_ALLI) != 0;
         if (acct_on && stop) begin
            acct_on = 0; acct_cnt += now - acct_at; acct_at = now;
         end else if (!acct_on && !stop) begin
            acct_on = 1; unacct_cnt += now - acct_at; acct_at = now;
         end
         if (stl_on && stop) begin
            stl_on = 0; stl_cnt += now - stl_at; stl_at = now;
         end else if (!stl_on && !stop && p2) begin
            stl_on = 1; nstl_cnt += now - stl_at; stl_at = now;
         end
      endfunction

      function void note_request(bit [3:0] act, bit sel, bit [ADDR_BITS-1:0] la,
                                 bit [ADDR_BITS-1:0] ca, bit [1:0] kind,
                                 bit [TIME_BITS-1:0] now);
         rsp_beat_type r;
         int s;
         r = '0;
         case (act)
            ACT_MISS: begin
               s = -1;
               for (int i = MISS_SLOTS - 1; i >= 0; i--)
                  if (!(sel ? i_flag[i][0] : d_flag[i][0])) s = i;
               if (s < 0) begin
                  r.status = ST_FULL; fulls++;
               end else if (sel) begin
                  i_addr[s] = la; i_flag[s] = 2'b01;
               end else begin
                  d_addr[s] = la; d_flag[s] = 2'b01; d_cpu[s] = 0;
               end
               regate(now);
            end
            ACT_SQUASH: begin
               s = find_slot(0, la);
               if (s >= 0) d_flag[s] = 0;
               s = find_slot(1, la);
               if (s >= 0) i_flag[s] = 0;
            end
            ACT_RESOLVE, ACT_MARK: begin
               s = find_slot(sel, la);
               if (s < 0) begin
                  r.status = ST_NOTFOUND; misses_nf++;
               end else if (act == ACT_RESOLVE) begin
                  if (sel) i_flag[s] = 0; else d_flag[s] = 0;
               end else if (sel) i_flag[s][1] = 1;
               else begin
                  d_flag[s][1] = 1; d_cpu[s] = ca;
               end
               regate(now);
            end
            ACT_STALL, ACT_RESUME: begin
               if (kind == stall_src) begin
                  sig = (act == ACT_STALL) ? (sig | S_STALL) : (sig & ~S_STALL);
                  regate(now);
               end
            end
            ACT_HEAD: begin
               head = la; regate(now);
            end
            ACT_CLEAR: begin
               head = 0; regate(now);
            end
            ACT_EMPTY, ACT_NONEMP: begin
               sig = (act == ACT_EMPTY) ? (sig | S_ROBE) : (sig & ~S_ROBE);
               regate(now);
            end
            ACT_SAMPLE: begin
               if (acct_on) acct_cnt += now - acct_at;
               else unacct_cnt += now - acct_at;
               acct_at = now;
               if (stl_on) stl_cnt += now - stl_at;
               else nstl_cnt += now - stl_at;
               stl_at = now;
               r.acc = acct_cnt; r.stl = stl_cnt;
               acct_cnt = 0; unacct_cnt = 0; stl_cnt = 0; nstl_cnt = 0;
               samples++;
            end
            default: ;
         endcase
         r.acct = acct_on;
         pending = {pending, r};
      endfunction

      function void check_response(rsp_beat_type got);
         rsp_beat_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected response beat");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status); errors++;
         end
         if (got.acct !== e.acct) begin
            $error("accounting_now: expected %0d, got %0d", e.acct, got.acct); errors++;
         end
         if (got.acc !== e.acc) begin
            $error("accounted_cycles: expected %0d, got %0d", e.acc, got.acc); errors++;
         end
         if (got.stl !== e.stl) begin
            $error("stall_cycles: expected %0d, got %0d", e.stl, got.stl); errors++;
         end
      endfunction
   endclass

   logic                 clock = 0, reset = 1;
   logic                 req_valid = 0, req_stall;
   logic [3:0]           req_action = 0;
   logic                 req_table_select = 0;
   logic [ADDR_BITS-1:0] req_line_addr = 0, req_cpu_addr = 0;
   logic [1:0]           req_stall_kind = 0;
   logic [TIME_BITS-1:0] req_now = 0;
   logic                 rsp_valid, rsp_stall = 0;
   logic [1:0]           rsp_status;
   logic                 rsp_accounting_now;
   logic [TIME_BITS-1:0] rsp_accounted_cycles, rsp_stall_cycles;
   logic                 csr_write = 0, csr_index = 0;
   logic [1:0]           csr_data = 0;

   itca_scoreboard       sb = new();
   bit                   quiet = 0;
   int                   cycles = 0;
   bit [TIME_BITS-1:0]   clk_now = 0;
   bit [ADDR_BITS-1:0]   pool[8];
   bit [ADDR_BITS-1:0]   head_addr = 0;

   intertask_conflict_cycle_accounting u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   int rsp_hold = 0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_status, rsp_accounting_now, rsp_accounted_cycles,
                            rsp_stall_cycles});
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1;
         rsp_hold <= $urandom_range(1, 19);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send(bit [3:0] act, bit sel, bit [ADDR_BITS-1:0] la,
                       bit [ADDR_BITS-1:0] ca, bit [1:0] kind, bit [TIME_BITS-1:0] now);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act; req_table_select <= sel; req_line_addr <= la;
      req_cpu_addr <= ca; req_stall_kind <= kind; req_now <= now;
      do @(posedge clock); while (req_stall);
      sb.note_request(act, sel, la, ca, kind, now);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(bit idx, bit [1:0] val);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.set_csr(idx, val);
   endtask

   task automatic random_event();
      bit [3:0]           act;
      bit [ADDR_BITS-1:0] la, ca;
      int                 w;
      w = $urandom_range(0, 99);
      if (w < 20) act = ACT_MISS;
      else if (w < 36) act = ACT_MARK;
      else if (w < 48) act = ACT_RESOLVE;
      else if (w < 54) act = ACT_SQUASH;
      else if (w < 60) act = ACT_STALL;
      else if (w < 66) act = ACT_RESUME;
      else if (w < 74) act = ACT_HEAD;
      else if (w < 77) act = ACT_CLEAR;
      else if (w < 82) act = ACT_EMPTY;
      else if (w < 87) act = ACT_NONEMP;
      else if (w < 95) act = ACT_SAMPLE;
      else act = 4'($urandom_range(11, 15));
      la = ($urandom_range(0, 9) == 0) ? ADDR_BITS'({$urandom, $urandom})
                                       : pool[$urandom_range(0, 7)];
      if (act == ACT_HEAD) head_addr = la;
      ca = ($urandom_range(0, 2) != 0) ? head_addr : ADDR_BITS'({$urandom, $urandom});
      if ($urandom_range(0, 30) == 0)
         pool[$urandom_range(0, 7)] = ADDR_BITS'({$urandom, $urandom});
      if ($urandom_range(0, 200) == 0) clk_now = '1 - $urandom_range(0, 100);
      else clk_now += $urandom_range(0, 60);
      send(act, 1'($urandom_range(0, 1)), la, ca, 2'($urandom_range(0, 3)), clk_now);
   endtask

   initial begin
      bit [1:0] srcs[4] = '{2'd1, 2'd0, 2'd2, 2'd1};
      bit       pols[4] = '{1'b0, 1'b1, 1'b0, 1'b1};
      foreach (pool[i]) pool[i] = ADDR_BITS'({$urandom, $urandom});
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_csr(CSR_STALL_SRC, 2'd1);
      write_csr(CSR_ITIP, 2'd0);

      send(ACT_RESOLVE, 0, '1, 0, 1, 0);
      send(ACT_SQUASH, 1, 0, 0, 1, 1);
      send(ACT_HEAD, 0, '1, 0, 1, 5);
      send(ACT_MISS, 0, '1, 0, 1, 9);
      send(ACT_MARK, 0, '1, '1, 1, 20);
      send(ACT_STALL, 0, 0, 0, 1, 30);
      send(ACT_SAMPLE, 0, 0, 0, 0, 44);
      send(ACT_RESUME, 0, 0, 0, 3, 50);
      send(ACT_RESUME, 0, 0, 0, 1, 51);
      send(ACT_CLEAR, 0, 0, 0, 0, 60);
      send(ACT_MISS, 1, 48'h0, 0, 0, 70);
      send(ACT_MARK, 1, 48'h0, '1, 0, 71);
      send(ACT_EMPTY, 0, 0, 0, 0, 80);
      send(ACT_EMPTY, 0, 0, 0, 0, 81);
      send(ACT_NONEMP, 0, 0, 0, 0, 90);
      send(ACT_NOP, 0, '1, '1, 3, '1);
      send(4'd15, 1, 0, 0, 2, 100);
      send(ACT_SAMPLE, 0, 0, 0, 0, 48'h5);
      for (int i = 0; i < MISS_SLOTS; i++) send(ACT_MISS, 1, 48'(i), 0, 0, 200);
      clk_now = 300;

      for (int p = 0; p < 4; p++) begin
         drain();
         write_csr(CSR_STALL_SRC, srcs[p]);
         write_csr(CSR_ITIP, {1'b0, pols[p]});
         for (int n = 0; n < 340; n++) begin
            if (p == 3 && n == 240) quiet = 1;
            if (n == 170) begin
               drain();
            end
            random_event();
         end
      end
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d responses over 4 CSR settings: %0d samples, %0d table-full,",
               sb.checked, sb.samples, sb.fulls);
      $display("%0d not-found events, random idle on both channels.", sb.misses_nf);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
